// ===== sv/lshe_pkg.sv =====
// ----------------------------------------------------------------------------
// lshe_pkg: shared definitions of the line sensor hysteresis error block
// Sizes, register indices, reset values and the types passed between modules.
// ----------------------------------------------------------------------------
package lshe_pkg;

    localparam int CHANNELS    = 8;
    localparam int SAMPLE_BITS = 12;
    localparam int CAL_BITS    = 48;
    localparam int CAL_FIELDS  = 4;
    localparam int ERR_BITS    = 17;
    localparam int COUNT_BITS  = 4;
    localparam int RUN_BITS    = 8;
    localparam int INDEX_BITS  = 8;

    localparam logic [CAL_BITS-1:0] WHITE_CAL_RESET = 48'd68736258049000;
    localparam logic [CAL_BITS-1:0] BLACK_CAL_RESET = 48'd54989006439200;
    localparam logic [RUN_BITS-1:0] LIMIT_RESET     = 8'd20;

    typedef enum logic [INDEX_BITS-1:0] {
        REG_WHITE_CAL_LOW  = 8'd0,
        REG_WHITE_CAL_HIGH = 8'd1,
        REG_BLACK_CAL_LOW  = 8'd2,
        REG_BLACK_CAL_HIGH = 8'd3,
        REG_MIRROR_ORDER   = 8'd4,
        REG_WHITE_LIMIT    = 8'd5
    } reg_index_t;

    typedef logic [SAMPLE_BITS-1:0]            sample_t;
    typedef sample_t [CHANNELS-1:0]            samples_t;
    typedef logic signed [ERR_BITS-1:0]        error_t;

    typedef struct packed {
        samples_t upper;
        samples_t lower;
    } thresh_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        error_t                error;
        logic                  updated;
        logic [RUN_BITS-1:0]   run;
        logic                  finish;
    } merge_t;

endpackage

// ===== sv/lshe_cal.sv =====
// ----------------------------------------------------------------------------
// lshe_cal: configuration registers and per-channel thresholds
// Holds the calibration registers and keeps the two hysteresis thresholds of
// every channel in registers, refreshed together with each write.
// ----------------------------------------------------------------------------
module lshe_cal (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [lshe_pkg::INDEX_BITS-1:0]   cfg_index,
    input  logic [lshe_pkg::CAL_BITS-1:0]     cfg_data,
    output lshe_pkg::thresh_t                 thresh,
    output logic                              mirror,
    output logic [lshe_pkg::RUN_BITS-1:0]     limit
);

    localparam int SB       = lshe_pkg::SAMPLE_BITS;
    localparam int CB       = lshe_pkg::CAL_BITS;
    localparam int EXT_BITS = (lshe_pkg::CAL_FIELDS * SB > CB) ?
                              lshe_pkg::CAL_FIELDS * SB : CB;
    localparam int SUM_BITS = SB + 2;
    // floor(x / 3) as (x * RECIP) >> SHIFT, exact for every x below 2^SUM_BITS.
    localparam int SHIFT     = SUM_BITS + 2;
    localparam int RECIP_VAL = (2 ** SHIFT) / 3 + 1;
    localparam int RECIP_BITS = SHIFT - 1;
    localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(RECIP_VAL);
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    // Every calibration field resets to the same pair, so all channels share
    // one pair of thresholds straight out of reset.
    localparam int WHITE_RESET_LEVEL = int'(lshe_pkg::WHITE_CAL_RESET[SB-1:0]);
    localparam int BLACK_RESET_LEVEL = int'(lshe_pkg::BLACK_CAL_RESET[SB-1:0]);
    localparam int HI_RESET_LEVEL = (BLACK_RESET_LEVEL >= WHITE_RESET_LEVEL) ?
                                    BLACK_RESET_LEVEL : WHITE_RESET_LEVEL;
    localparam int LO_RESET_LEVEL = (BLACK_RESET_LEVEL >= WHITE_RESET_LEVEL) ?
                                    WHITE_RESET_LEVEL : BLACK_RESET_LEVEL;
    localparam lshe_pkg::sample_t UPPER_RESET =
        SB'((2 * HI_RESET_LEVEL + LO_RESET_LEVEL) / 3);
    localparam lshe_pkg::sample_t LOWER_RESET =
        SB'((HI_RESET_LEVEL + 2 * LO_RESET_LEVEL) / 3);

    logic [CB-1:0] white_low_reg, white_high_reg, black_low_reg, black_high_reg;
    logic [CB-1:0] white_low_next, white_high_next, black_low_next, black_high_next;
    logic          mirror_reg, mirror_next;
    logic [lshe_pkg::RUN_BITS-1:0] limit_reg, limit_next;
    lshe_pkg::thresh_t thresh_reg, thresh_next;

    function automatic lshe_pkg::sample_t div3(input logic [SUM_BITS-1:0] x);
        logic [PROD_BITS-1:0] prod;
        prod = PROD_BITS'(x) * PROD_BITS'(RECIP);
        return prod[SHIFT +: SB];
    endfunction

    always_comb
    begin
        white_low_next  = white_low_reg;
        white_high_next = white_high_reg;
        black_low_next  = black_low_reg;
        black_high_next = black_high_reg;
        mirror_next     = mirror_reg;
        limit_next      = limit_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lshe_pkg::REG_WHITE_CAL_LOW:  white_low_next  = cfg_data;
                lshe_pkg::REG_WHITE_CAL_HIGH: white_high_next = cfg_data;
                lshe_pkg::REG_BLACK_CAL_LOW:  black_low_next  = cfg_data;
                lshe_pkg::REG_BLACK_CAL_HIGH: black_high_next = cfg_data;
                lshe_pkg::REG_MIRROR_ORDER:   mirror_next     = cfg_data[0];
                lshe_pkg::REG_WHITE_LIMIT:
                    limit_next = cfg_data[lshe_pkg::RUN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [EXT_BITS-1:0] wreg, breg;
        lshe_pkg::sample_t   w, b, hi, lo;
        for (int ch = 0; ch < lshe_pkg::CHANNELS; ch++)
        begin
            wreg = (ch < lshe_pkg::CAL_FIELDS) ? EXT_BITS'(white_low_next)
                                               : EXT_BITS'(white_high_next);
            breg = (ch < lshe_pkg::CAL_FIELDS) ? EXT_BITS'(black_low_next)
                                               : EXT_BITS'(black_high_next);
            w = wreg[(ch % lshe_pkg::CAL_FIELDS) * SB +: SB];
            b = breg[(ch % lshe_pkg::CAL_FIELDS) * SB +: SB];
            // An inverted pair is swapped so that the upper level is the larger one.
            hi = (b >= w) ? b : w;
            lo = (b >= w) ? w : b;
            thresh_next.upper[ch] = div3({hi, 1'b0} + SUM_BITS'(lo));
            thresh_next.lower[ch] = div3(SUM_BITS'(hi) + {lo, 1'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_low_reg    <= lshe_pkg::WHITE_CAL_RESET;
            white_high_reg   <= lshe_pkg::WHITE_CAL_RESET;
            black_low_reg    <= lshe_pkg::BLACK_CAL_RESET;
            black_high_reg   <= lshe_pkg::BLACK_CAL_RESET;
            mirror_reg       <= 1'b0;
            limit_reg        <= lshe_pkg::LIMIT_RESET;
            thresh_reg.upper <= {lshe_pkg::CHANNELS{UPPER_RESET}};
            thresh_reg.lower <= {lshe_pkg::CHANNELS{LOWER_RESET}};
        end
        else
        begin
            white_low_reg  <= white_low_next;
            white_high_reg <= white_high_next;
            black_low_reg  <= black_low_next;
            black_high_reg <= black_high_next;
            mirror_reg     <= mirror_next;
            limit_reg      <= limit_next;
            thresh_reg     <= thresh_next;
        end
    end

    assign thresh = thresh_reg;
    assign mirror = mirror_reg;
    assign limit  = limit_reg;

endmodule

// ===== sv/lshe_lane.sv =====
// ----------------------------------------------------------------------------
// lshe_lane: hysteresis decision of one sensor channel
// Compares the reading with the channel's two thresholds and keeps the old
// state when the reading lies between them.
// ----------------------------------------------------------------------------
module lshe_lane (
    input  lshe_pkg::sample_t sample,
    input  lshe_pkg::sample_t upper,
    input  lshe_pkg::sample_t lower,
    input  logic              black_prev,
    output logic              black
);

    always_comb
    begin
        priority if (sample > upper)
            black = 1'b0;
        else if (sample < lower)
            black = 1'b1;
        else
            black = black_prev;
    end

endmodule

// ===== sv/lshe_merge.sv =====
// ----------------------------------------------------------------------------
// lshe_merge: combines the lane decisions of one frame
// Counts black channels, forms the weighted error and advances the white-run
// counter and the finish flag.
// ----------------------------------------------------------------------------
module lshe_merge (
    input  logic [lshe_pkg::CHANNELS-1:0]  black,
    input  lshe_pkg::samples_t             chan,
    input  lshe_pkg::error_t               held_error,
    input  logic [lshe_pkg::RUN_BITS-1:0]  run,
    input  logic                           finish,
    input  logic [lshe_pkg::RUN_BITS-1:0]  limit,
    output lshe_pkg::merge_t               result
);

    localparam int SB = lshe_pkg::SAMPLE_BITS;
    localparam int EB = lshe_pkg::ERR_BITS;
    localparam int WORK_BITS = (SB + 5 > EB) ? SB + 5 : EB;

    typedef logic signed [WORK_BITS-1:0] work_t;

    logic [lshe_pkg::COUNT_BITS-1:0] count;
    work_t                           sum;
    logic [lshe_pkg::RUN_BITS:0]     run_inc;

    function automatic work_t diff(input lshe_pkg::sample_t p, input lshe_pkg::sample_t q);
        return work_t'($signed({1'b0, p})) - work_t'($signed({1'b0, q}));
    endfunction

    always_comb
    begin
        count = '0;
        for (int i = 0; i < lshe_pkg::CHANNELS; i++)
            count = count + lshe_pkg::COUNT_BITS'(black[i]);
    end

    always_comb
    begin
        sum = (diff(chan[7], chan[0]) <<< 3) + (diff(chan[6], chan[1]) <<< 2)
            + (diff(chan[5], chan[2]) <<< 1) + diff(chan[4], chan[3]);
    end

    assign run_inc = {1'b0, run} + 1'b1;

    always_comb
    begin
        result.count   = count;
        result.updated = (count != '0);
        result.error   = held_error;
        result.run     = '0;
        result.finish  = finish;
        if (count != '0)
            result.error = sum[EB-1:0];
        else if (run_inc > {1'b0, limit})
            result.finish = 1'b1;
        else
            result.run = run_inc[lshe_pkg::RUN_BITS-1:0];
    end

endmodule

// ===== sv/line_sensor_hysteresis_error.sv =====
// ----------------------------------------------------------------------------
// line_sensor_hysteresis_error: line-follower sensor stage
// Turns a frame of eight sensor readings into black/white channel states with
// hysteresis and a weighted left-right steering error.
//
// A frame of eight 12-bit readings arrives as one request on the s_ group;
// each frame yields one result request on the m_ group. Calibration and
// options are written through the cfg channel, which is always ready; writes
// belong to idle periods between frames. Thresholds are refreshed in the
// cycle of the write, so a frame may follow the write directly.
// The result is registered. One frame is taken every cycle unless the receiver
// stalls: the eight channel lanes, the black count and the shift-add error all
// sit in front of a single output register, and the channel state carried from
// frame to frame is updated in that same cycle.
// When the receiver stalls, the output register holds its result and
// s_tready is high only while that register is empty or being emptied.
// Reset restores the calibration defaults, marks every channel white, clears
// the white-run counter, the held error and the finish flag, and empties the
// output register.
// ----------------------------------------------------------------------------
module line_sensor_hysteresis_error (
    input  logic                               clk,
    input  logic                               rst_n,
    // Fields from bit 0: sample_0 .. sample_7, 12 bits each.
    input  logic [lshe_pkg::CHANNELS*lshe_pkg::SAMPLE_BITS-1:0] s_tdata,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: black_bits[8], black_count[4], steer_error[17],
    // finish_flag[1], two zero bits.
    output logic [31:0]                        m_tdata,
    // Fields from bit 0: error_updated.
    output logic                               m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lshe_pkg::INDEX_BITS-1:0]    cfg_index,
    input  logic [lshe_pkg::CAL_BITS-1:0]      cfg_data
);

    localparam int CH = lshe_pkg::CHANNELS;
    localparam int SB = lshe_pkg::SAMPLE_BITS;

    lshe_pkg::thresh_t             thresh;
    logic                          mirror;
    logic [lshe_pkg::RUN_BITS-1:0] limit;
    lshe_pkg::samples_t            chan;
    logic [CH-1:0]                 black;
    lshe_pkg::merge_t              merged;
    logic                          accept;

    logic [CH-1:0]                 black_reg;
    logic [lshe_pkg::RUN_BITS-1:0] run_reg;
    lshe_pkg::error_t              held_reg;
    logic                          finish_reg;
    logic                          out_valid_reg;
    logic [31:0]                   out_data_reg;
    logic                          out_user_reg;

    assign cfg_ready = 1'b1;

    lshe_cal u_cal (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thresh    (thresh),
        .mirror    (mirror),
        .limit     (limit)
    );

    always_comb
    begin
        for (int i = 0; i < CH; i++)
            chan[i] = mirror ? s_tdata[(CH - 1 - i) * SB +: SB] : s_tdata[i * SB +: SB];
    end

    for (genvar g = 0; g < CH; g++)
    begin : g_lane
        lshe_lane u_lane (
            .sample     (chan[g]),
            .upper      (thresh.upper[g]),
            .lower      (thresh.lower[g]),
            .black_prev (black_reg[g]),
            .black      (black[g])
        );
    end

    lshe_merge u_merge (
        .black      (black),
        .chan       (chan),
        .held_error (held_reg),
        .run        (run_reg),
        .finish     (finish_reg),
        .limit      (limit),
        .result     (merged)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg     <= '0;
            run_reg       <= '0;
            held_reg      <= '0;
            finish_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                black_reg     <= black;
                run_reg       <= merged.run;
                held_reg      <= merged.error;
                finish_reg    <= merged.finish;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= {2'b00, merged.finish, merged.error, merged.count, black};
            out_user_reg <= merged.updated;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
